[rtl/core/srx_pkg.sv]
// Package for the serial packet receiver: frame constants, register codes and types.
`timescale 1ns / 1ps

package srx_pkg;

  // Frame layout
  localparam int unsigned MaxPayload = 12;
  localparam int unsigned HdrLen     = 6;
  localparam int unsigned WideSize   = 12;
  localparam int unsigned NarrowSize = 1;

  localparam logic [7:0] StartA    = 8'h24;  // '$'
  localparam logic [7:0] StartB    = 8'h14;
  localparam logic [7:0] CheckMask = 8'hFE;

  // Widths derived from the payload bound
  localparam int unsigned PosW = $clog2(MaxPayload + HdrLen + 1);
  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;

  // Header positions within a frame
  localparam logic [PosW-1:0] PosStartA = PosW'(0);
  localparam logic [PosW-1:0] PosStartB = PosW'(1);
  localparam logic [PosW-1:0] PosLength = PosW'(2);
  localparam logic [PosW-1:0] PosCmd    = PosW'(3);
  localparam logic [PosW-1:0] PosCheck1 = PosW'(4);
  localparam logic [PosW-1:0] PosCheck2 = PosW'(5);
  localparam logic [PosW-1:0] PosHdrEnd = PosW'(HdrLen);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MOVE_CARTESIAN = 2'd0,
    CFG_MOVE_POLAR     = 2'd1,
    CFG_ORIENTATION    = 2'd2,
    CFG_STATE_CMD      = 2'd3
  } cfg_index_t;

  typedef logic [7:0] byte_t;

  // Command codes held in the configuration registers
  typedef struct packed {
    byte_t cartesian;
    byte_t polar;
    byte_t orientation;
    byte_t state_cmd;
  } cmd_codes_t;

  // Payload size of a command, zero when invalid or above the payload bound
  function automatic logic [7:0] payload_size(input byte_t code, input cmd_codes_t codes);
    logic [7:0] n;
    n = 8'd0;
    priority if (code == codes.cartesian)    n = 8'(WideSize);
    else if (code == codes.polar)            n = 8'(WideSize);
    else if (code == codes.orientation)      n = 8'(WideSize);
    else if (code == codes.state_cmd)        n = 8'(NarrowSize);
    else                                     n = 8'd0;
    if (n > 8'(MaxPayload)) n = 8'd0;
    return n;
  endfunction

endpackage

[rtl/core/serial_packet_receiver_core.sv]
// Top level of the serial packet receiver: frame parser, checksum and payload emitter.
`timescale 1ns / 1ps

// Takes one received byte per transfer on the s_ side and assembles frames of the form
// '$', 0x14, length, command, check1, check2, payload. A wrong start byte, an unknown
// command or a length that does not match the command drops the byte and restarts the
// frame. When the last payload byte arrives the checksums are checked in the same cycle
// and a good packet is copied into an output buffer, from which one payload byte per
// transfer leaves on the m_ side (tlast on the final byte). The input stalls only when a
// frame is about to complete while the output buffer still holds bytes of the previous
// packet; the closing byte is then taken in the cycle after the last buffered byte has
// left, so back-pressure on the m_ side lengthens the stall.
module serial_packet_receiver_core (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,     // [7:0] rx_byte
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata,     // [7:0] command, [15:8] data_byte,
                                                     // [19:16] byte_index, [23:20] zero
  output logic                          m_tlast,     // last_flag
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  srx_pkg::cfg_index_t           cfg_index,
  input  logic [7:0]                    cfg_data
);
  import srx_pkg::*;

  // Configuration registers
  cmd_codes_t codes;

  // Frame state
  logic [PosW-1:0] frame_position, frame_position_next;
  byte_t           length_byte, command_byte, first_check, second_check;
  byte_t           running_xor, running_xor_next;
  byte_t           payload_store [MaxPayload];

  // Output buffer
  logic            busy;
  byte_t           emit_cmd;
  byte_t           emit_buf [MaxPayload];
  logic [IdxW-1:0] emit_idx;
  logic [IdxW-1:0] emit_last;

  // Decode of the current byte
  logic            in_xfer, out_xfer;
  logic            in_payload;
  logic [PosW-1:0] pay_off;
  logic [IdxW-1:0] wr_idx;
  logic            wr_ok;
  logic            completes;
  logic            check_pass;
  byte_t           c1, c2;
  byte_t           cmd_size;
  logic [7:0]      n_bytes;

  assign cfg_ready = 1'b1;

  // Payload write decode and the frame position at which the byte in hand closes the frame
  assign in_payload = (frame_position >= PosHdrEnd);
  assign pay_off    = frame_position - PosHdrEnd;
  assign wr_ok      = in_payload && (pay_off < PosW'(MaxPayload)) && (length_byte > 8'(HdrLen));
  assign wr_idx     = pay_off[IdxW-1:0];
  assign completes  = wr_ok && (8'(frame_position) + 8'd1 == length_byte);

  assign s_tready = !(busy && completes);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // Checksums over the finished frame, payload size of the command and payload byte count
  assign running_xor_next = running_xor ^ s_tdata;
  assign c1         = (length_byte ^ command_byte ^ running_xor_next) & CheckMask;
  assign c2         = (~c1) & CheckMask;
  assign check_pass = (c1 == first_check) && (c2 == second_check);
  assign cmd_size   = payload_size(s_tdata, codes);
  assign n_bytes    = ((length_byte - 8'(HdrLen)) > 8'(MaxPayload)) ?
                      8'(MaxPayload) : (length_byte - 8'(HdrLen));

  // Next frame position
  always_comb begin
    frame_position_next = frame_position;
    priority if (frame_position == PosStartA) begin
      if (s_tdata == StartA) frame_position_next = PosStartB;
    end else if (frame_position == PosStartB) begin
      frame_position_next = (s_tdata == StartB) ? PosLength : PosStartA;
    end else if (frame_position == PosLength) begin
      frame_position_next = PosCmd;
    end else if (frame_position == PosCmd) begin
      if (cmd_size == 8'd0 || length_byte != 8'(HdrLen) + cmd_size)
        frame_position_next = PosStartA;
      else
        frame_position_next = PosCheck1;
    end else if (frame_position == PosCheck1) begin
      frame_position_next = PosCheck2;
    end else if (frame_position == PosCheck2) begin
      frame_position_next = PosHdrEnd;
    end else begin
      if (!wr_ok || completes) frame_position_next = PosStartA;
      else                     frame_position_next = frame_position + PosW'(1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.cartesian    <= 8'd1;
      codes.polar        <= 8'd2;
      codes.orientation  <= 8'd3;
      codes.state_cmd    <= 8'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MOVE_CARTESIAN: codes.cartesian    <= cfg_data;
        CFG_MOVE_POLAR:     codes.polar        <= cfg_data;
        CFG_ORIENTATION:    codes.orientation  <= cfg_data;
        CFG_STATE_CMD:      codes.state_cmd    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= PosStartA;
      running_xor    <= 8'd0;
    end else if (in_xfer) begin
      frame_position <= frame_position_next;
      if (frame_position_next == PosStartA || frame_position == PosCheck2)
        running_xor <= 8'd0;
      else if (in_payload)
        running_xor <= running_xor_next;
    end
  end

  // Header fields and payload capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (frame_position == PosLength) length_byte  <= s_tdata;
      if (frame_position == PosCmd)    command_byte <= s_tdata;
      if (frame_position == PosCheck1) first_check  <= s_tdata;
      if (frame_position == PosCheck2) second_check <= s_tdata;
      if (wr_ok) payload_store[wr_idx] <= s_tdata;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      emit_idx <= '0;
    end else if (in_xfer && completes && check_pass) begin
      busy     <= 1'b1;
      emit_idx <= '0;
    end else if (out_xfer) begin
      if (emit_idx == emit_last) busy <= 1'b0;
      emit_idx <= emit_idx + IdxW'(1);
    end
  end

  // Output buffer load, the closing byte taken straight from the input
  always_ff @(posedge clk) begin
    if (in_xfer && completes && check_pass) begin
      emit_cmd  <= command_byte;
      emit_last <= IdxW'(n_bytes - 8'd1);
      for (int i = 0; i < MaxPayload; i++) begin
        emit_buf[i] <= (IdxW'(i) == wr_idx) ? s_tdata : payload_store[i];
      end
    end
  end

  // Result fields
  assign m_tvalid = busy;
  assign m_tlast  = (emit_idx == emit_last);
  assign m_tdata  = {4'd0, 4'(emit_idx), emit_buf[emit_idx], emit_cmd};

endmodule

[sim/tb_top.sv]
// Testbench for serial_packet_receiver_core: random framed traffic checked against a packet model.
`timescale 1ns / 1ps

module tb_top;
  import srx_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseBytes  = 12;

  // One payload byte as it leaves the m_ side
  typedef struct packed {
    byte_t      command;
    byte_t      data_byte;
    logic [3:0] byte_index;
    logic       last_flag;
  } payload_item_t;

  // Frame parser model plus the queue of payload bytes it still expects
  class payload_checker;
    cmd_codes_t    codes;
    int unsigned   pos;
    byte_t         len_b;
    byte_t         cmd_b;
    byte_t         chk1;
    byte_t         chk2;
    byte_t         xor_acc;
    byte_t         store [MaxPayload];
    payload_item_t expected_bytes [$];
    int unsigned   errors;
    int unsigned   results_checked;
    int unsigned   results_predicted;
    int unsigned   packets_passed;

    function new();
      codes.cartesian    = 8'd1;
      codes.polar        = 8'd2;
      codes.orientation  = 8'd3;
      codes.state_cmd    = 8'd4;
      pos = 0;
      len_b = '0;
      cmd_b = '0;
      chk1 = '0;
      chk2 = '0;
      xor_acc = '0;
      errors = 0;
      results_checked = 0;
      results_predicted = 0;
      packets_passed = 0;
    endfunction

    function void set_code(cfg_index_t r, byte_t v);
      case (r)
        CFG_MOVE_CARTESIAN: codes.cartesian    = v;
        CFG_MOVE_POLAR:     codes.polar        = v;
        CFG_ORIENTATION:    codes.orientation  = v;
        CFG_STATE_CMD:      codes.state_cmd    = v;
        default: ;
      endcase
    endfunction

    // First matching register wins; zero means the code is not accepted
    function int unsigned size_of(byte_t c);
      int unsigned n;
      if (c == codes.cartesian) n = WideSize;
      else if (c == codes.polar) n = WideSize;
      else if (c == codes.orientation) n = WideSize;
      else if (c == codes.state_cmd) n = NarrowSize;
      else n = 0;
      if (n > MaxPayload) n = 0;
      return n;
    endfunction

    function void restart_frame();
      pos = 0;
      xor_acc = '0;
    endfunction

    // Advance the parser by one received byte, queue payload bytes of a good packet
    function void take_rx_byte(byte_t b);
      int unsigned   n;
      int unsigned   k;
      byte_t         c1;
      byte_t         c2;
      payload_item_t it;
      if (pos == 0) begin
        if (b == StartA) pos = 1;
      end else if (pos == 1) begin
        if (b == StartB) pos = 2;
        else restart_frame();
      end else if (pos == 2) begin
        len_b = b;
        pos = 3;
      end else if (pos == 3) begin
        cmd_b = b;
        n = size_of(b);
        if (n == 0 || int'(len_b) != int'(HdrLen + n)) restart_frame();
        else pos = 4;
      end else if (pos == 4) begin
        chk1 = b;
        pos = 5;
      end else if (pos == 5) begin
        chk2 = b;
        xor_acc = '0;
        pos = 6;
      end else begin
        k = pos - HdrLen;
        if (k >= MaxPayload || len_b <= HdrLen) begin
          restart_frame();
        end else begin
          store[k] = b;
          xor_acc ^= b;
          pos = pos + 1;
          if (pos == len_b) begin
            c1 = (len_b ^ cmd_b ^ xor_acc) & CheckMask;
            c2 = (~c1) & CheckMask;
            restart_frame();
            if (c1 == chk1 && c2 == chk2) begin
              n = len_b - HdrLen;
              if (n > MaxPayload) n = MaxPayload;
              for (k = 0; k < n; k++) begin
                it.command    = cmd_b;
                it.data_byte  = store[k];
                it.byte_index = 4'(k);
                it.last_flag  = (k + 1 == n);
                expected_bytes = {expected_bytes, it};
              end
              results_predicted += n;
              packets_passed++;
            end
          end
        end
      end
    endfunction

    function void check_payload_byte(payload_item_t got);
      payload_item_t exp_it;
      results_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected payload byte: command %h data %h index %0d last %b",
               got.command, got.data_byte, got.byte_index, got.last_flag);
        errors++;
      end else begin
        exp_it = expected_bytes.pop_front();
        if (got.command !== exp_it.command) begin
          $error("command: expected %h, got %h", exp_it.command, got.command);
          errors++;
        end
        if (got.data_byte !== exp_it.data_byte) begin
          $error("data_byte: expected %h, got %h", exp_it.data_byte, got.data_byte);
          errors++;
        end
        if (got.byte_index !== exp_it.byte_index) begin
          $error("byte_index: expected %0d, got %0d", exp_it.byte_index, got.byte_index);
          errors++;
        end
        if (got.last_flag !== exp_it.last_flag) begin
          $error("last_flag: expected %b, got %b", exp_it.last_flag, got.last_flag);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [7:0]  cfg_data;

  payload_checker chk = new();
  byte_t          tx_frame [$];
  bit             no_idle = 1'b0;
  int unsigned    bytes_sent = 0;
  int unsigned    cycle_count = 0;

  serial_packet_receiver_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("serial_packet_receiver_core test failed");
      $finish;
    end
  end

  // Monitor: input transfers feed the model, output transfers get checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) chk.take_rx_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        chk.check_payload_byte('{command: m_tdata[7:0], data_byte: m_tdata[15:8],
                                 byte_index: m_tdata[19:16], last_flag: m_tlast});
      end
    end
  end

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Append one byte to the outgoing stream
  function automatic void add_tx_byte(input byte_t b);
    tx_frame = {tx_frame, b};
  endfunction

  // Output side: random back-pressure before each transfer
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // One input transfer; leaves tvalid high so the next byte can follow back to back
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_queued();
    byte_t b;
    while (tx_frame.size() != 0) begin
      b = tx_frame.pop_front();
      send_byte(b);
      bytes_sent++;
    end
  endtask

  // Hold the input until every predicted payload byte has left
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (chk.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t r, input byte_t v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    chk.set_code(r, v);
    @(negedge clk);
  endtask

  task automatic program_codes(input byte_t c0, input byte_t c1, input byte_t c2,
                               input byte_t c3);
    write_reg(CFG_MOVE_CARTESIAN, c0);
    write_reg(CFG_MOVE_POLAR, c1);
    write_reg(CFG_ORIENTATION, c2);
    write_reg(CFG_STATE_CMD, c3);
    cfg_valid <= 1'b0;
  endtask

  // Queue a full frame; fill < 0 gives a random payload, corrupt spoils one check byte
  task automatic push_frame(input byte_t cmd, input byte_t len, input int unsigned n,
                            input int fill, input bit corrupt);
    byte_t       pl [$];
    byte_t       acc;
    byte_t       c1;
    byte_t       c2;
    byte_t       v;
    int unsigned i;
    acc = '0;
    for (i = 0; i < n; i++) begin
      v = (fill < 0) ? 8'($urandom) : 8'(fill);
      pl = {pl, v};
      acc ^= v;
    end
    c1 = (len ^ cmd ^ acc) & CheckMask;
    c2 = (~c1) & CheckMask;
    if (corrupt) begin
      if ($urandom_range(0, 1)) c1 ^= 8'(1 << $urandom_range(0, 7));
      else c2 ^= 8'(1 << $urandom_range(0, 7));
    end
    add_tx_byte(StartA);
    add_tx_byte(StartB);
    add_tx_byte(len);
    add_tx_byte(cmd);
    add_tx_byte(c1);
    add_tx_byte(c2);
    foreach (pl[j]) add_tx_byte(pl[j]);
  endtask

  task automatic push_header(input byte_t len, input byte_t cmd);
    add_tx_byte(StartA);
    add_tx_byte(StartB);
    add_tx_byte(len);
    add_tx_byte(cmd);
  endtask

  // Mostly good packets with random content, the rest broken frames and noise
  task automatic queue_random_frame();
    int unsigned kind;
    int unsigned n;
    int unsigned i;
    byte_t       cmd;
    byte_t       len;
    byte_t       b;
    kind = $urandom_range(0, 99);
    no_idle = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0:       cmd = chk.codes.cartesian;
      1:       cmd = chk.codes.polar;
      2:       cmd = chk.codes.orientation;
      default: cmd = chk.codes.state_cmd;
    endcase
    n = chk.size_of(cmd);
    if (kind < 65) begin
      push_frame(cmd, 8'(HdrLen + n), n, -1, 1'b0);
    end else if (kind < 75) begin
      push_frame(cmd, 8'(HdrLen + n), n, -1, 1'b1);
    end else if (kind < 82) begin
      // length that does not fit the command
      len = $urandom_range(0, 1) ? 8'(HdrLen + ((n == WideSize) ? NarrowSize : WideSize))
                                 : 8'($urandom);
      while (int'(len) == int'(HdrLen + n)) len = 8'($urandom);
      push_header(len, cmd);
    end else if (kind < 88) begin
      // command code that no register holds
      cmd = 8'($urandom);
      while (chk.size_of(cmd) != 0) cmd = 8'($urandom);
      push_header(8'(HdrLen + ($urandom_range(0, 1) ? WideSize : NarrowSize)), cmd);
    end else if (kind < 93) begin
      // bad second start byte
      b = 8'($urandom);
      while (b == StartB) b = 8'($urandom);
      add_tx_byte(StartA);
      add_tx_byte(b);
    end else begin
      for (i = 0; i < $urandom_range(1, 3); i++) add_tx_byte(8'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned budget);
    int unsigned phase_start;
    phase_start = bytes_sent;
    while (bytes_sent - phase_start < budget) begin
      queue_random_frame();
      send_queued();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  // Main sequence
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MOVE_CARTESIAN;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset codes: directed corner cases first
    program_codes(8'd1, 8'd2, 8'd3, 8'd4);
    add_tx_byte(StartB);                     // stray byte while hunting for a start
    add_tx_byte(StartA);
    add_tx_byte(StartA);                     // second start byte wrong, not a new start
    push_header(8'(HdrLen + NarrowSize), 8'h09);  // code held by no register
    push_header(8'(HdrLen + WideSize), chk.codes.state_cmd);  // length mismatch
    push_frame(chk.codes.state_cmd, 8'(HdrLen + NarrowSize), NarrowSize, 8'hFF, 1'b0);
    push_frame(chk.codes.state_cmd, 8'(HdrLen + NarrowSize), NarrowSize, 8'h00, 1'b1);
    send_queued();
    run_random(PhaseBytes);
    wait_drained();

    // Extreme code values
    program_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
    run_random(PhaseBytes);
    wait_drained();

    // All registers equal: the first one decides the payload size
    program_codes(8'h55, 8'h55, 8'h55, 8'h55);
    run_random(PhaseBytes);
    wait_drained();

    // Random codes
    program_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(PhaseBytes);
    wait_drained();

    // Codes that look like frame bytes, partial overlap
    program_codes(StartA, StartB, StartA, 8'hFE);
    run_random(PhaseBytes);
    wait_drained();

    $display("Sent %0d bytes over 5 code settings; %0d packets passed the checksum.",
             bytes_sent, chk.packets_passed);
    $display("Checked %0d of %0d predicted payload bytes, %0d mismatches.",
             chk.results_checked, chk.results_predicted, chk.errors);
    if (chk.errors == 0) begin
      $display("serial_packet_receiver_core test passed");
    end else begin
      $display("serial_packet_receiver_core test failed");
    end
    $finish;
  end

endmodule
